>>> hdl/smeu_pkg.sv
// Shared types and constants for the stack machine execute unit.
package smeu_pkg;

  // Fixed sizes of the machine
  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = 7;
  localparam int PC_W        = 8;
  localparam int WORD_W      = 32;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = 6;

  // Opcodes
  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_PUSH  = 4'd1;
  localparam logic [3:0] OP_DROP  = 4'd2;
  localparam logic [3:0] OP_DUP   = 4'd3;
  localparam logic [3:0] OP_SWAP  = 4'd4;
  localparam logic [3:0] OP_OVER  = 4'd5;
  localparam logic [3:0] OP_EMIT  = 4'd6;
  localparam logic [3:0] OP_JUMP  = 4'd7;
  localparam logic [3:0] OP_JMPZ  = 4'd8;
  localparam logic [3:0] OP_ADD   = 4'd9;
  localparam logic [3:0] OP_SUB   = 4'd10;
  localparam logic [3:0] OP_MUL   = 4'd11;
  localparam logic [3:0] OP_DIV   = 4'd12;

  // Status codes
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;
  localparam logic [2:0] ST_BADT  = 3'd5;
  localparam logic [2:0] ST_UNK   = 3'd6;
  localparam logic [2:0] ST_STOP  = 3'd7;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] operand_byte;
  } in_beat_t;

  typedef struct packed {
    logic [PC_W-1:0]           next_pc;
    logic                      print_valid;
    logic signed [WORD_W-1:0]  print_value;
    logic [2:0]                status;
    logic [DEPTH_W-1:0]        depth;
  } out_beat_t;

  // Whole-stack move applied to the row of cells
  typedef enum logic [2:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP,
    SH_POPSET,
    SH_SWAP
  } shift_t;

  // Per-cell source select
  typedef enum logic [1:0] {
    CS_HOLD,
    CS_UP,
    CS_DOWN
  } cell_sel_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_DIV
  } ctl_state_t;

endpackage

>>> hdl/smeu_cell.sv
// One stack cell: holds a word or takes it from the neighbor above or below.
module smeu_cell
  import smeu_pkg::*;
(
  input  logic              clk,
  input  cell_sel_t         sel,
  input  logic [WORD_W-1:0] from_up,
  input  logic [WORD_W-1:0] from_down,
  output logic [WORD_W-1:0] q
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // Pick the source for this cycle
  always_comb begin
    case (sel)
      CS_UP:   word_nxt = from_up;
      CS_DOWN: word_nxt = from_down;
      CS_HOLD: word_nxt = word_r;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

>>> hdl/smeu_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module smeu_div
  import smeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;
  logic [WORD_W-1:0]    dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_W+1:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    trial    = {1'b0, rem_r, quo_r[WORD_W-1]} - {2'b00, dvs_r};
    if (start) begin
      // load magnitudes and the result sign
      rem_nxt  = '0;
      quo_nxt  = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt  = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      // restoring step: shift in the next dividend bit, subtract when it fits
      if (!trial[WORD_W+1]) begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

>>> hdl/stack_machine_execute_unit_core.sv
// Execute core of a byte-coded stack machine: control, stack cell row and divider.
//
// Each input beat is one fetched instruction (opcode and following byte); each
// accepted beat yields exactly one result beat with the next fetch address,
// any printed value, a status code and the stack depth. The data stack is a
// row of 64 cells with the top of stack in cell 0; every push, pop or swap
// moves the words one cell along the row. All instructions except divide
// execute in the cycle they are accepted, so a new instruction can be taken
// every cycle while the result side keeps up. Divide runs on an iterative
// divider that produces one quotient bit per cycle: its result beat is
// registered once the divider is done and the result side is free, and no
// other instruction is accepted before that. After a halt or any fault the
// core answers every instruction with status "stopped" and leaves its state
// alone until reset. The stack contents are not cleared by reset, which
// clears the depth and program counter, sets the run flag and goes idle.
module stack_machine_execute_unit_core
  import smeu_pkg::*;
#(
  parameter int MEMORY_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam logic [PC_W:0] MEM_LIMIT = (PC_W+1)'(MEMORY_BYTES);

  ctl_state_t         state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic               run_r, run_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  shift_t             shift;
  logic [WORD_W-1:0]  load_val;
  logic [WORD_W-1:0]  cell_q [STACK_DEPTH];

  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_quo;

  logic               out_free;
  logic               accept;
  logic [PC_W:0]      pc_inc1, pc_inc2;
  logic [PC_W-1:0]    pc1, pc2;
  logic [WORD_W-1:0]  top, second;
  logic               empty, lt2, full, bad_target;

  logic [2:0]         st;
  logic [PC_W-1:0]    npc;
  logic               pv;
  logic [WORD_W-1:0]  pval;
  logic [DEPTH_W-1:0] dres;
  logic               go_div;
  logic               fault;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != CTL_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Program counter advances, wrapped to the memory size
  assign pc_inc1 = {1'b0, pc_r} + (PC_W+1)'(1);
  assign pc_inc2 = {1'b0, pc_r} + (PC_W+1)'(2);
  assign pc1 = (pc_inc1 >= MEM_LIMIT) ? PC_W'(pc_inc1 - MEM_LIMIT) : pc_inc1[PC_W-1:0];
  assign pc2 = (pc_inc2 >= MEM_LIMIT) ? PC_W'(pc_inc2 - MEM_LIMIT) : pc_inc2[PC_W-1:0];

  // Stack condition flags
  assign top        = cell_q[0];
  assign second     = cell_q[1];
  assign empty      = (depth_r == '0);
  assign lt2        = (depth_r < DEPTH_W'(2));
  assign full       = (depth_r == DEPTH_W'(STACK_DEPTH));
  assign bad_target = ({1'b0, in_data.operand_byte} >= MEM_LIMIT);

  // Decode the instruction against the current stack
  always_comb begin
    st       = ST_RUN;
    npc      = pc1;
    pv       = 1'b0;
    pval     = '0;
    dres     = depth_r;
    shift    = SH_HOLD;
    load_val = '0;
    go_div   = 1'b0;
    case (in_data.command)
      OP_HALT: st = ST_HALT;
      OP_PUSH: begin
        npc = pc2;
        if (full) begin
          st = ST_OVER;
        end else begin
          shift    = SH_PUSH;
          load_val = WORD_W'(in_data.operand_byte);
          dres     = depth_r + 1'b1;
        end
      end
      OP_DROP: begin
        if (empty) begin
          st = ST_UNDER;
        end else begin
          shift = SH_POP;
          dres  = depth_r - 1'b1;
        end
      end
      OP_DUP: begin
        if (empty) begin
          st = ST_UNDER;
        end else if (full) begin
          st = ST_OVER;
        end else begin
          shift    = SH_PUSH;
          load_val = top;
          dres     = depth_r + 1'b1;
        end
      end
      OP_SWAP: begin
        if (lt2) begin
          st = ST_UNDER;
        end else begin
          shift = SH_SWAP;
        end
      end
      OP_OVER: begin
        if (lt2) begin
          st = ST_UNDER;
        end else if (full) begin
          st = ST_OVER;
        end else begin
          shift    = SH_PUSH;
          load_val = second;
          dres     = depth_r + 1'b1;
        end
      end
      OP_EMIT: begin
        if (empty) begin
          st = ST_UNDER;
        end else begin
          shift = SH_POP;
          dres  = depth_r - 1'b1;
          pv    = 1'b1;
          pval  = top;
        end
      end
      OP_JUMP: begin
        if (bad_target) begin
          st = ST_BADT;
        end else begin
          npc = in_data.operand_byte;
        end
      end
      OP_JMPZ: begin
        npc = pc2;
        if (bad_target) begin
          st = ST_BADT;
        end else if (empty) begin
          st = ST_UNDER;
        end else begin
          shift = SH_POP;
          dres  = depth_r - 1'b1;
          if (top == '0) begin
            npc = in_data.operand_byte;
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        if (lt2) begin
          st = ST_UNDER;
        end else begin
          shift = SH_POPSET;
          dres  = depth_r - 1'b1;
          case (in_data.command)
            OP_ADD:  load_val = second + top;
            OP_SUB:  load_val = second - top;
            default: load_val = second * top;
          endcase
        end
      end
      OP_DIV: begin
        if (lt2) begin
          st = ST_UNDER;
        end else if (top == '0) begin
          st = ST_DIVZ;
        end else begin
          go_div = 1'b1;
        end
      end
      default: st = ST_UNK;
    endcase
    fault = (st != ST_RUN) && (st != ST_HALT);
  end

  // Sequence the core: commit, fault, stop, hand off to the divider, or finish a divide
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    pc_nxt        = pc_r;
    run_nxt       = run_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      CTL_IDLE: begin
        if (accept) begin
          if (!run_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.next_pc     = pc_r;
            out_data_nxt.print_valid = 1'b0;
            out_data_nxt.print_value = '0;
            out_data_nxt.status      = ST_STOP;
            out_data_nxt.depth       = depth_r;
          end else if (go_div) begin
            div_start = 1'b1;
            state_nxt = CTL_DIV;
          end else if (fault) begin
            run_nxt                  = 1'b0;
            out_valid_nxt            = 1'b1;
            out_data_nxt.next_pc     = pc_r;
            out_data_nxt.print_valid = 1'b0;
            out_data_nxt.print_value = '0;
            out_data_nxt.status      = st;
            out_data_nxt.depth       = depth_r;
          end else begin
            pc_nxt                   = npc;
            depth_nxt                = dres;
            run_nxt                  = (st != ST_HALT);
            out_valid_nxt            = 1'b1;
            out_data_nxt.next_pc     = npc;
            out_data_nxt.print_valid = pv;
            out_data_nxt.print_value = pval;
            out_data_nxt.status      = st;
            out_data_nxt.depth       = dres;
          end
        end
      end
      CTL_DIV: begin
        if (div_done && out_free) begin
          pc_nxt                   = pc1;
          depth_nxt                = depth_r - 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.next_pc     = pc1;
          out_data_nxt.print_valid = 1'b0;
          out_data_nxt.print_value = '0;
          out_data_nxt.status      = ST_RUN;
          out_data_nxt.depth       = depth_r - 1'b1;
          state_nxt                = CTL_IDLE;
        end
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  // Stack move actually applied this cycle
  shift_t             row_shift;
  logic [WORD_W-1:0]  row_load;

  always_comb begin
    row_shift = SH_HOLD;
    row_load  = load_val;
    if (state_r == CTL_IDLE) begin
      if (accept && run_r && !fault && !go_div) begin
        row_shift = shift;
      end
    end else if (div_done && out_free) begin
      row_shift = SH_POPSET;
      row_load  = div_quo;
    end
  end

  // Row of stack cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_sel_t         sel;
    logic [WORD_W-1:0] up_word;
    logic [WORD_W-1:0] down_word;

    if (i == 0) begin : g_top
      assign up_word = row_load;
    end else begin : g_mid
      assign up_word = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_word = '0;
    end else begin : g_above
      assign down_word = cell_q[i+1];
    end

    always_comb begin
      case (row_shift)
        SH_PUSH:   sel = CS_UP;
        SH_POP:    sel = CS_DOWN;
        SH_POPSET: sel = (i == 0) ? CS_UP : CS_DOWN;
        SH_SWAP:   sel = (i == 0) ? CS_DOWN : ((i == 1) ? CS_UP : CS_HOLD);
        SH_HOLD:   sel = CS_HOLD;
        default:   sel = CS_HOLD;
      endcase
    end

    smeu_cell u_cell (
      .clk       (clk),
      .sel       (sel),
      .from_up   (up_word),
      .from_down (down_word),
      .q         (cell_q[i])
    );
  end

  // Divider: second over top
  smeu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (second),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      depth_r     <= '0;
      pc_r        <= '0;
      run_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      pc_r        <= pc_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

>>> test/tb_stack_machine_execute_unit_core.sv
// Testbench for the stack machine execute core: self-predicting instruction scoreboard.
module tb_stack_machine_execute_unit_core;
  import smeu_pkg::*;

  localparam int MEM_BYTES   = 256;
  localparam int TOTAL_INSTR = 850;
  localparam int DRAIN_WAIT  = 40;

  typedef enum int {END_HALT, END_OVERFLOW, END_UNDERFLOW, END_DIVZERO, END_UNKNOWN} end_kind_t;

  // Track the machine state and the results each accepted instruction is due to produce
  class exec_tracker;
    logic [WORD_W-1:0] cells [STACK_DEPTH];
    int                depth;
    logic [PC_W-1:0]   pc;
    bit                running;
    out_beat_t         due_results[$];
    int                errors, instrs, divides, prints, stopped_instrs;

    function new();
      depth   = 0;
      pc      = '0;
      running = 1'b1;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    // True when the instruction would execute without halting or faulting
    function bit runs_clean(in_beat_t b);
      case (b.command)
        OP_PUSH:                 return depth < STACK_DEPTH;
        OP_DROP, OP_EMIT,
        OP_JMPZ:                 return depth >= 1;
        OP_DUP:                  return depth >= 1 && depth < STACK_DEPTH;
        OP_SWAP, OP_ADD,
        OP_SUB, OP_MUL:          return depth >= 2;
        OP_OVER:                 return depth >= 2 && depth < STACK_DEPTH;
        OP_DIV:                  return depth >= 2 && cells[depth-1] != '0;
        OP_JUMP:                 return 1'b1;
        default:                 return 1'b0;
      endcase
    endfunction

    // Execute one accepted instruction and queue the result it must produce
    function void retire_instr(in_beat_t b);
      logic [WORD_W-1:0] s [STACK_DEPTH];
      logic [WORD_W-1:0] a, c, ua, uc, q;
      logic [PC_W-1:0]   pc1, pc2, npc;
      logic [2:0]        st;
      logic              pv;
      logic [WORD_W-1:0] pval;
      out_beat_t         e;
      int                d;
      s    = cells;
      d    = depth;
      pc1  = PC_W'((int'(pc) + 1) % MEM_BYTES);
      pc2  = PC_W'((int'(pc) + 2) % MEM_BYTES);
      npc  = pc1;
      st   = ST_RUN;
      pv   = 1'b0;
      pval = '0;
      instrs++;
      if (!running) begin
        st = ST_STOP;
        npc = pc;
        stopped_instrs++;
      end else begin
        case (b.command)
          OP_HALT: st = ST_HALT;
          OP_PUSH: begin
            npc = pc2;
            if (d >= STACK_DEPTH) st = ST_OVER;
            else begin
              s[d] = WORD_W'(b.operand_byte);
              d++;
            end
          end
          OP_DROP: begin
            if (d < 1) st = ST_UNDER;
            else d--;
          end
          OP_DUP: begin
            if (d < 1) st = ST_UNDER;
            else if (d >= STACK_DEPTH) st = ST_OVER;
            else begin
              s[d] = s[d-1];
              d++;
            end
          end
          OP_SWAP: begin
            if (d < 2) st = ST_UNDER;
            else begin
              s[d-2] = cells[d-1];
              s[d-1] = cells[d-2];
            end
          end
          OP_OVER: begin
            if (d < 2) st = ST_UNDER;
            else if (d >= STACK_DEPTH) st = ST_OVER;
            else begin
              s[d] = s[d-2];
              d++;
            end
          end
          OP_EMIT: begin
            if (d < 1) st = ST_UNDER;
            else begin
              d--;
              pv = 1'b1;
              pval = s[d];
            end
          end
          OP_JUMP: begin
            if (int'(b.operand_byte) >= MEM_BYTES) st = ST_BADT;
            else npc = b.operand_byte;
          end
          OP_JMPZ: begin
            npc = pc2;
            if (int'(b.operand_byte) >= MEM_BYTES) st = ST_BADT;
            else if (d < 1) st = ST_UNDER;
            else begin
              d--;
              if (s[d] == '0) npc = b.operand_byte;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (d < 2) st = ST_UNDER;
            else begin
              a = s[d-2];
              c = s[d-1];
              if (b.command == OP_DIV && c == '0) st = ST_DIVZ;
              else begin
                case (b.command)
                  OP_ADD: a = a + c;
                  OP_SUB: a = a - c;
                  OP_MUL: a = a * c;
                  default: begin
                    // Divide magnitudes, then fix the sign; truncates toward zero
                    ua = a[WORD_W-1] ? -a : a;
                    uc = c[WORD_W-1] ? -c : c;
                    q  = ua / uc;
                    a  = (a[WORD_W-1] != c[WORD_W-1]) ? -q : q;
                    divides++;
                  end
                endcase
                d--;
                s[d-1] = a;
              end
            end
          end
          default: st = ST_UNK;
        endcase

        // Commit on success; a fault leaves the state as it was
        if (st >= ST_OVER) begin
          d    = depth;
          npc  = pc;
          pv   = 1'b0;
          pval = '0;
          running = 1'b0;
        end else begin
          cells = s;
          depth = d;
          pc    = npc;
          if (pv) prints++;
          if (st == ST_HALT) running = 1'b0;
        end
      end
      e.next_pc     = npc;
      e.print_valid = pv;
      e.print_value = pval;
      e.status      = st;
      e.depth       = DEPTH_W'(d);
      due_results.push_back(e);
    endfunction

    // Compare one result beat with the oldest outstanding expectation
    function void match_result(out_beat_t r);
      out_beat_t e;
      if (due_results.size() == 0) begin
        $error("result beat with none outstanding: next_pc %0d status %0d", r.next_pc, r.status);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (r.next_pc !== e.next_pc) begin
        $error("next_pc: expected %0d, got %0d", e.next_pc, r.next_pc);
        errors++;
      end
      if (r.print_valid !== e.print_valid) begin
        $error("print_valid: expected %0d, got %0d", e.print_valid, r.print_valid);
        errors++;
      end
      if (r.print_value !== e.print_value) begin
        $error("print_value: expected %0d, got %0d", e.print_value, r.print_value);
        errors++;
      end
      if (r.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, r.status);
        errors++;
      end
      if (r.depth !== e.depth) begin
        $error("depth: expected %0d, got %0d", e.depth, r.depth);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  exec_tracker tracker = new();
  int          sent    = 0;
  bit          climbing = 1'b1;
  end_kind_t   end_kind;

  stack_machine_execute_unit_core #(.MEMORY_BYTES(MEM_BYTES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle mix: sender-light first, then receiver-light, then none
  function automatic int mix();
    int m;
    m = sent * 3 / TOTAL_INSTR;
    return (m > 2) ? 2 : m;
  endfunction

  function automatic int send_gap_pct();
    case (mix())
      0:       return 24;
      1:       return 71;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (mix())
      0:       return 71;
      1:       return 24;
      default: return 0;
    endcase
  endfunction

  // Present one instruction beat and hold it until it is accepted
  task automatic issue(logic [3:0] cmd, logic [7:0] arg);
    in_beat_t b;
    b.command      = cmd;
    b.operand_byte = arg;
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    tracker.retire_instr(b);
    sent++;
  endtask

  // Pick a clean instruction, drifting the stack between empty and full
  function automatic in_beat_t next_random_instr();
    in_beat_t b;
    int       r;
    logic [3:0] grow [3]   = '{OP_PUSH, OP_DUP, OP_OVER};
    logic [3:0] shrink [7] = '{OP_DROP, OP_EMIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JMPZ};
    if (tracker.depth >= STACK_DEPTH) climbing = 1'b0;
    else if (tracker.depth == 0) climbing = 1'b1;
    else if ($urandom_range(0, 39) == 0) climbing = !climbing;
    do begin
      r = $urandom_range(0, 99);
      if (r < 60) b.command = climbing ? grow[$urandom_range(0, 2)] : shrink[$urandom_range(0, 6)];
      else b.command = 4'($urandom_range(OP_PUSH, OP_DIV));
      b.operand_byte = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    end while (!tracker.runs_clean(b));
    return b;
  endfunction

  // Stop the program by one randomly chosen means
  task automatic end_program();
    logic [3:0] starve [10] = '{OP_DROP, OP_DUP, OP_SWAP, OP_OVER, OP_EMIT,
                                OP_JMPZ, OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    logic [3:0] fill [3]    = '{OP_PUSH, OP_DUP, OP_OVER};
    end_kind = end_kind_t'($urandom_range(END_HALT, END_UNKNOWN));
    case (end_kind)
      END_HALT: issue(OP_HALT, 8'($urandom_range(0, 255)));
      END_OVERFLOW: begin
        while (tracker.depth < STACK_DEPTH) issue(OP_PUSH, 8'($urandom_range(0, 255)));
        issue(fill[$urandom_range(0, 2)], 8'($urandom_range(0, 255)));
      end
      END_UNDERFLOW: begin
        while (tracker.depth > 0) issue(OP_DROP, 8'($urandom_range(0, 255)));
        issue(starve[$urandom_range(0, 9)], 8'($urandom_range(0, 255)));
      end
      END_DIVZERO: begin
        while (tracker.depth > STACK_DEPTH - 2) issue(OP_DROP, 8'($urandom_range(0, 255)));
        issue(OP_PUSH, 8'($urandom_range(0, 255)));
        issue(OP_PUSH, 8'd0);
        issue(OP_DIV, 8'($urandom_range(0, 255)));
      end
      default: issue(4'($urandom_range(13, 15)), 8'($urandom_range(0, 255)));
    endcase
  endtask

  // Stimulus: reset, directed program, random program, then stop and probe
  initial begin
    in_beat_t b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode except halt, extremes, wrap, INT_MIN / -1, negative truncation
    issue(OP_PUSH, 8'd255);
    issue(OP_PUSH, 8'd0);
    issue(OP_ADD, 8'd0);
    issue(OP_DUP, 8'd255);
    issue(OP_OVER, 8'd0);
    issue(OP_SWAP, 8'd0);
    issue(OP_DROP, 8'd0);
    issue(OP_SUB, 8'd0);
    issue(OP_JMPZ, 8'h40);
    issue(OP_PUSH, 8'd128);
    issue(OP_DUP, 8'd0);
    issue(OP_MUL, 8'd0);
    issue(OP_DUP, 8'd0);
    issue(OP_MUL, 8'd0);
    issue(OP_PUSH, 8'd8);
    issue(OP_MUL, 8'd0);
    issue(OP_PUSH, 8'd0);
    issue(OP_PUSH, 8'd1);
    issue(OP_SUB, 8'd0);
    issue(OP_DIV, 8'd0);
    issue(OP_EMIT, 8'd0);
    issue(OP_PUSH, 8'd1);
    issue(OP_JMPZ, 8'h10);
    issue(OP_JUMP, 8'hFF);
    issue(OP_PUSH, 8'd0);
    issue(OP_PUSH, 8'd7);
    issue(OP_SUB, 8'd0);
    issue(OP_PUSH, 8'd2);
    issue(OP_DIV, 8'd0);

    // Random well-formed program
    while (sent < TOTAL_INSTR - 90) begin
      b = next_random_instr();
      issue(b.command, b.operand_byte);
    end

    // Stop the machine, then confirm it stays stopped for any opcode
    end_program();
    repeat (20) issue(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d instructions (%0d divides, %0d prints) under three idle/stall mixes,",
             tracker.instrs, tracker.divides, tracker.prints);
    $display("ended by %s and followed by %0d instructions in the stopped state.",
             end_kind.name(), tracker.stopped_instrs);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random stall, sample accepted beats, check them at the falling edge
  initial begin
    out_beat_t r;
    bit        got;
    forever begin
      @(posedge clk);
      got = rst_n && out_valid && !out_stall;
      r   = out_data;
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
      if (got) begin
        @(negedge clk);
        tracker.match_result(r);
      end
    end
  end

  // Watchdog
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
